FILE: src/cbm_pkg.sv
// cbm_pkg: types and constants shared by the cartridge bank mapper
// transfer payload structs, register write struct, config bit fields and target codes
// no dependencies
`default_nettype none

package cbm_pkg;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int MADDR_W = 22;
    localparam int OFS_W   = 13;

    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_RAM  = 2'd1;
    localparam logic [1:0] TGT_ROM  = 2'd2;

    localparam int CFG_LOCK_BIT     = 7;
    localparam int CFG_ROM_WP_BIT   = 6;
    localparam int CFG_BLK5_RAM_BIT = 5;
    localparam int CFG_A21_BIT      = 0;

    localparam logic [DATA_W-1:0] CFG_SEL_MASK = 8'h18;
    localparam logic [DATA_W-1:0] CFG_SEL_BLK1 = 8'h18;
    localparam logic [DATA_W-1:0] CFG_SEL_R123 = 8'h08;
    localparam logic [DATA_W-1:0] CFG_WMASK    = 8'hf9;
    localparam logic [DATA_W-1:0] CFG_RESET    = 8'h40;
    localparam logic [DATA_W-1:0] BANK_RESET   = 8'h00;

    localparam logic [MADDR_W-1:0] R123_BASE = 22'h002000;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] video_bus_last;
        logic [DATA_W-1:0] cpu_bus_last;
    } t_in;

    typedef struct packed {
        logic               decoded;
        logic [1:0]         target;
        logic [MADDR_W-1:0] mem_addr;
        logic               mem_write;
        logic [DATA_W-1:0]  read_data;
    } t_out;

    typedef struct packed {
        logic              bank_we;
        logic              cfg_we;
        logic [DATA_W-1:0] data;
    } t_reg_wr;

endpackage

`default_nettype wire

FILE: src/cbm_decode.sv
// cbm_decode: window decode and address translation for one bus access
// gives the result item and the register write for the current bank and config
// depends on cbm_pkg
`default_nettype none

module cbm_decode (
    input  var cbm_pkg::t_in                   i_item,
    input  var logic [cbm_pkg::DATA_W-1:0]     i_bank,
    input  var logic [cbm_pkg::DATA_W-1:0]     i_cfg,
    output cbm_pkg::t_out                      o_result,
    output cbm_pkg::t_reg_wr                   o_reg_wr
);
    import cbm_pkg::*;

    logic [ADDR_W-1:0] a;
    logic              wr;
    logic              win_r123;
    logic              win_blk1;
    logic              win_blk23;
    logic              win_io2;
    logic              win_blk5;

    assign a  = i_item.address;
    assign wr = i_item.op;

    assign win_r123  = (a[15:12] == 4'h0) && (a[11:10] != 2'b00);
    assign win_blk1  = (a[15:13] == 3'b001);
    assign win_blk23 = (a[15:14] == 2'b01);
    assign win_io2   = (a[15:10] == 6'b100110);
    assign win_blk5  = (a[15:13] == 3'b101);

    always_comb begin
        o_result           = '0;
        o_reg_wr.bank_we   = 1'b0;
        o_reg_wr.cfg_we    = 1'b0;
        o_reg_wr.data      = i_item.write_data;
        if (win_r123) begin
            o_result.decoded = 1'b1;
            if ((i_cfg & CFG_SEL_MASK) == CFG_SEL_R123) begin
                o_result.target    = TGT_RAM;
                o_result.mem_addr  = MADDR_W'(a) + R123_BASE;
                o_result.mem_write = wr;
            end else if (!wr) begin
                o_result.read_data = i_item.video_bus_last;
            end
        end else if (win_blk1) begin
            o_result.decoded = 1'b1;
            if ((i_cfg & CFG_SEL_MASK) == CFG_SEL_BLK1) begin
                o_result.target    = TGT_RAM;
                o_result.mem_addr  = MADDR_W'(a);
                o_result.mem_write = wr;
            end else if (!wr) begin
                o_result.read_data = i_item.cpu_bus_last;
            end
        end else if (win_blk23) begin
            o_result.decoded   = 1'b1;
            o_result.target    = TGT_RAM;
            o_result.mem_addr  = MADDR_W'(a);
            o_result.mem_write = wr;
        end else if (win_io2) begin
            o_result.decoded = 1'b1;
            if (i_cfg[CFG_LOCK_BIT]) begin
                if (!wr) begin
                    o_result.read_data = i_item.cpu_bus_last;
                end
            end else if (a[0]) begin
                if (wr) begin
                    o_reg_wr.cfg_we = 1'b1;
                end else begin
                    o_result.read_data = i_cfg;
                end
            end else begin
                if (wr) begin
                    o_reg_wr.bank_we = 1'b1;
                end else begin
                    o_result.read_data = i_bank;
                end
            end
        end else if (win_blk5) begin
            o_result.decoded = 1'b1;
            if (i_cfg[CFG_BLK5_RAM_BIT]) begin
                o_result.target    = TGT_RAM;
                o_result.mem_addr  = MADDR_W'(a[OFS_W-1:0]);
                o_result.mem_write = wr;
            end else if (!wr || !i_cfg[CFG_ROM_WP_BIT]) begin
                o_result.target    = TGT_ROM;
                o_result.mem_addr  = {i_cfg[CFG_A21_BIT], i_bank, a[OFS_W-1:0]};
                o_result.mem_write = wr;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/cartridge_bank_mapper.sv
// cartridge_bank_mapper: input register, decode, result register
// one decode pass between the registers; a result loads once the result register is free
// throughput: one access per cycle unless the output stalls, set by that single decode pass
// reset: bank register 0x00, config register 0x40, both stages empty
// depends on cbm_pkg and cbm_decode
`default_nettype none

module cartridge_bank_mapper (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_in_valid,
    output logic              o_in_ready,
    input  var cbm_pkg::t_in  i_in,
    output logic              o_out_valid,
    input  var logic          i_out_ready,
    output cbm_pkg::t_out     o_out
);
    import cbm_pkg::*;

    logic              r_in_vld;
    t_in               r_in;
    logic              r_out_vld;
    t_out              r_out;
    logic [DATA_W-1:0] r_bank;
    logic [DATA_W-1:0] r_cfg;

    logic              out_free;
    logic              advance;
    logic              in_take;
    t_out              n_out;
    t_reg_wr           reg_wr;

    cbm_decode u_decode (
        .i_item   (r_in),
        .i_bank   (r_bank),
        .i_cfg    (r_cfg),
        .o_result (n_out),
        .o_reg_wr (reg_wr)
    );

    assign out_free   = !r_out_vld || i_out_ready;
    assign advance    = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_bank    <= BANK_RESET;
            r_cfg     <= CFG_RESET;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (advance && reg_wr.bank_we) begin
                r_bank <= reg_wr.data;
            end
            if (advance && reg_wr.cfg_we) begin
                r_cfg <= reg_wr.data & CFG_WMASK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // lock holds both registers until reset
    a_lock_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg[CFG_LOCK_BIT] |=> r_cfg[CFG_LOCK_BIT] && $stable(r_bank))
        else $error("locked registers changed");

    a_cfg_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cfg & ~CFG_WMASK) == '0)
        else $error("config register holds masked bits");

    a_no_target_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.target == TGT_NONE) |-> (r_out.mem_addr == '0 && !r_out.mem_write))
        else $error("memory address or strobe without target");

    a_target_decoded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.decoded) |-> (r_out.target == TGT_NONE && r_out.read_data == '0))
        else $error("result outside windows not empty");

endmodule

`default_nettype wire

FILE: test/tb_cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// tb_cartridge_bank_mapper: self-checking bench for the cartridge bank mapper
// predicts every bus access result from its own copy of the bank and config registers
// depends on cbm_pkg and the cartridge_bank_mapper top level

module tb_cartridge_bank_mapper;

    import cbm_pkg::*;

    localparam logic [15:0] R123_LO = 16'h0400, R123_HI = 16'h0fff;
    localparam logic [15:0] BLK1_LO = 16'h2000, BLK1_HI = 16'h3fff;
    localparam logic [15:0] BLK23_LO = 16'h4000, BLK23_HI = 16'h7fff;
    localparam logic [15:0] IO2_LO = 16'h9800, IO2_HI = 16'h9bff;
    localparam logic [15:0] BLK5_LO = 16'ha000, BLK5_HI = 16'hbfff;
    localparam logic [12:0] OFS_MASK = 13'h1fff;
    localparam logic [7:0] CFG_LOCK = 8'h80;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int RANDOM_ACCESSES = 1500;
    localparam int LOCK_POINT      = 1350;

    typedef enum int unsigned {
        WIN_OUTSIDE, WIN_R123, WIN_BLK1, WIN_BLK23, WIN_IO2, WIN_BLK5
    } t_window;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  in_valid = 1'b0;
    t_in   in_data = '0;
    logic  out_ready = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_out  o_out;

    t_in   access_queue[$];
    t_out  bus_replies[$];

    logic [7:0]  bank_copy;
    logic [7:0]  cfg_copy;
    int unsigned send_wait = 0;
    int unsigned take_wait = 0;
    bit          send_calm = 1'b0;
    bit          take_calm = 1'b0;
    int          errors = 0;

    cartridge_bank_mapper u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_out decode_access(t_in acc);
        t_out r;
        logic wr;
        logic [15:0] a;
        r = '0;
        wr = (acc.op == OP_WRITE);
        a = acc.address;
        if (a >= R123_LO && a <= R123_HI) begin
            r.decoded = 1'b1;
            if ((cfg_copy & CFG_SEL_MASK) == CFG_SEL_R123) begin
                r.target = TGT_RAM;
                r.mem_addr = MADDR_W'(a[12:0]) + R123_BASE;
                r.mem_write = wr;
            end else if (!wr) begin
                r.read_data = acc.video_bus_last;
            end
        end else if (a >= BLK1_LO && a <= BLK1_HI) begin
            r.decoded = 1'b1;
            if ((cfg_copy & CFG_SEL_MASK) == CFG_SEL_BLK1) begin
                r.target = TGT_RAM;
                r.mem_addr = MADDR_W'(a);
                r.mem_write = wr;
            end else if (!wr) begin
                r.read_data = acc.cpu_bus_last;
            end
        end else if (a >= BLK23_LO && a <= BLK23_HI) begin
            r.decoded = 1'b1;
            r.target = TGT_RAM;
            r.mem_addr = MADDR_W'(a);
            r.mem_write = wr;
        end else if (a >= IO2_LO && a <= IO2_HI) begin
            r.decoded = 1'b1;
            if (cfg_copy[CFG_LOCK_BIT]) begin
                if (!wr) r.read_data = acc.cpu_bus_last;
            end else if (a[0]) begin
                if (wr) cfg_copy = acc.write_data & CFG_WMASK;
                else r.read_data = cfg_copy;
            end else begin
                if (wr) bank_copy = acc.write_data;
                else r.read_data = bank_copy;
            end
        end else if (a >= BLK5_LO && a <= BLK5_HI) begin
            r.decoded = 1'b1;
            if (cfg_copy[CFG_BLK5_RAM_BIT]) begin
                r.target = TGT_RAM;
                r.mem_addr = MADDR_W'(a & OFS_MASK);
                r.mem_write = wr;
            end else if (!wr || !cfg_copy[CFG_ROM_WP_BIT]) begin
                r.target = TGT_ROM;
                r.mem_addr = {cfg_copy[CFG_A21_BIT], bank_copy, a[12:0]};
                r.mem_write = wr;
            end
        end
        return r;
    endfunction

    task automatic push_access(logic op, logic [15:0] addr, logic [7:0] wdata);
        t_in acc;
        acc.op = op;
        acc.address = addr;
        acc.write_data = wdata;
        acc.video_bus_last = 8'($urandom);
        acc.cpu_bus_last = 8'($urandom);
        access_queue.push_back(acc);
    endtask

    function automatic logic [15:0] span_pick(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic push_random(bit allow_lock);
        int unsigned w;
        t_window win;
        logic [15:0] addr;
        logic [7:0] wdata;
        logic op;
        w = $urandom_range(0, 16);
        if (w < 2) win = WIN_OUTSIDE;
        else if (w < 5) win = WIN_R123;
        else if (w < 8) win = WIN_BLK1;
        else if (w < 10) win = WIN_BLK23;
        else if (w < 13) win = WIN_IO2;
        else win = WIN_BLK5;
        case (win)
            WIN_OUTSIDE: begin
                case ($urandom_range(0, 4))
                    0: addr = span_pick(16'h0000, 16'h03ff);
                    1: addr = span_pick(16'h1000, 16'h1fff);
                    2: addr = span_pick(16'h8000, 16'h97ff);
                    3: addr = span_pick(16'h9c00, 16'h9fff);
                    default: addr = span_pick(16'hc000, 16'hffff);
                endcase
            end
            WIN_R123: addr = span_pick(R123_LO, R123_HI);
            WIN_BLK1: addr = span_pick(BLK1_LO, BLK1_HI);
            WIN_BLK23: addr = span_pick(BLK23_LO, BLK23_HI);
            WIN_IO2: addr = span_pick(IO2_LO, IO2_HI);
            default: addr = span_pick(BLK5_LO, BLK5_HI);
        endcase
        op = 1'($urandom);
        wdata = 8'($urandom);
        if (win == WIN_IO2 && !allow_lock) wdata = wdata & ~CFG_LOCK;
        push_access(op, addr, wdata);
    endtask

    // stimulus driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_wait = 0;
        end else if (in_valid && o_in_ready) begin
            bus_replies.push_back(decode_access(in_data));
            if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
            send_wait = send_calm ? 0 : $urandom_range(0, 16);
            if (send_wait == 0 && access_queue.size() != 0) begin
                in_data <= access_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end else if (!in_valid) begin
            if (send_wait != 0) begin
                send_wait--;
            end else if (access_queue.size() != 0) begin
                in_valid <= 1'b1;
                in_data <= access_queue.pop_front();
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            take_wait = 0;
        end else if (o_out_valid && out_ready) begin
            if (bus_replies.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t unexpected result: got %h", $realtime, o_out);
            end else begin
                want = bus_replies.pop_front();
                if (o_out.decoded !== want.decoded || o_out.target !== want.target ||
                    o_out.mem_addr !== want.mem_addr || o_out.mem_write !== want.mem_write ||
                    o_out.read_data !== want.read_data) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t mismatch: exp dec=%b tgt=%0d addr=%h wr=%b rd=%h, got dec=%b tgt=%0d addr=%h wr=%b rd=%h",
                                 $realtime, want.decoded, want.target, want.mem_addr,
                                 want.mem_write, want.read_data, o_out.decoded, o_out.target,
                                 o_out.mem_addr, o_out.mem_write, o_out.read_data);
                end
            end
            if ($urandom_range(0, 31) == 0) take_calm = !take_calm;
            take_wait = take_calm ? 0 : $urandom_range(0, 16);
            if (take_wait != 0) out_ready <= 1'b0;
        end else if (!out_ready) begin
            if (take_wait != 0) take_wait--;
            else out_ready <= 1'b1;
        end
    end

    initial begin
        #2_000_000;
        $display("tb_cartridge_bank_mapper failed");
        $finish;
    end

    initial begin
        bank_copy = BANK_RESET;
        cfg_copy = CFG_RESET;

        // reset values, disabled windows, the always-on blk23 window and the write-protected rom
        push_access(OP_READ, 16'h9801, 8'h00);
        push_access(OP_READ, 16'h9800, 8'h00);
        push_access(OP_READ, R123_LO, 8'h00);
        push_access(OP_WRITE, R123_HI, 8'hff);
        push_access(OP_READ, BLK1_LO, 8'h00);
        push_access(OP_WRITE, BLK1_HI, 8'hff);
        push_access(OP_READ, BLK23_LO, 8'h00);
        push_access(OP_WRITE, BLK23_HI, 8'h5a);
        push_access(OP_READ, BLK5_LO, 8'h00);
        push_access(OP_WRITE, BLK5_HI, 8'ha5);
        // outside every window
        push_access(OP_READ, 16'h0000, 8'h00);
        push_access(OP_WRITE, 16'hffff, 8'hff);
        push_access(OP_READ, 16'h03ff, 8'h00);
        push_access(OP_WRITE, 16'h1fff, 8'h11);
        push_access(OP_READ, 16'h97ff, 8'h00);
        push_access(OP_WRITE, 16'h9c00, 8'h22);
        push_access(OP_READ, 16'h9fff, 8'h00);
        push_access(OP_WRITE, 16'hc000, 8'h33);
        // ram123 enabled, rom unprotected with top bank
        push_access(OP_WRITE, IO2_HI, 8'h0f);
        push_access(OP_WRITE, IO2_LO, 8'hff);
        push_access(OP_READ, R123_LO, 8'h00);
        push_access(OP_WRITE, R123_HI, 8'h44);
        push_access(OP_WRITE, BLK5_HI, 8'h55);
        push_access(OP_READ, BLK5_LO, 8'h00);
        // blk1 enabled and blk5 ram, masked bits dropped
        push_access(OP_WRITE, 16'h9801, 8'h7e);
        push_access(OP_READ, BLK1_LO, 8'h00);
        push_access(OP_WRITE, BLK1_HI, 8'h66);
        push_access(OP_WRITE, BLK5_HI, 8'h77);
        push_access(OP_READ, IO2_HI, 8'h00);

        for (int i = 0; i < RANDOM_ACCESSES; i++) begin
            if (i == LOCK_POINT) begin
                push_access(OP_WRITE, 16'h9801, CFG_LOCK | 8'($urandom));
                push_access(OP_READ, 16'h9801, 8'h00);
            end
            push_random(i > LOCK_POINT);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (access_queue.size() != 0 || in_valid) @(posedge i_clk);
        while (bus_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb_cartridge_bank_mapper passed");
        end else begin
            $display("tb_cartridge_bank_mapper failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/cbm_pkg.sv
src/cbm_decode.sv
src/cartridge_bank_mapper.sv
test/tb_cartridge_bank_mapper.sv
